// ===== hdl/suffix_automaton_builder_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the suffix automaton builder.
// Both macros sample on the rising edge of clock and are disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SUFFIX_AUTOMATON_BUILDER_ASSERT_SVH
`define SUFFIX_AUTOMATON_BUILDER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SAB_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("suffix automaton builder check failed");
`define SAB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("suffix automaton builder check failed");
`else
`define SAB_ASSERT_SAME(lbl, ante, cons)
`define SAB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/sab_pkg.sv =====
// ---------------------------------------------------------------------------
// sab_pkg
// Sizes, types and controller codes shared by the suffix automaton builder.
// ---------------------------------------------------------------------------
package sab_pkg;
   localparam int MAX_LEN  = 4096;
   localparam int ALPHABET = 26;
   localparam int NODES    = 2 * MAX_LEN;
   localparam int NODE_W   = $clog2(NODES);
   localparam int LEN_W    = $clog2(MAX_LEN + 1);
   localparam int SYMBOL_W = 5;
   localparam int NEW_W    = 13;
   localparam int TOTAL_W  = 24;
   localparam int ROW_W    = ALPHABET * NODE_W;

   typedef logic [NODE_W-1:0]   node_type;
   typedef logic [LEN_W-1:0]    len_type;
   typedef logic [ROW_W-1:0]    row_type;
   typedef logic [SYMBOL_W-1:0] symbol_type;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_START, ST_WALK_RD, ST_WALK_CHK, ST_Q_RD, ST_Q_CHK,
      ST_LINK_Q, ST_LINK_NODE, ST_RED_RD, ST_RED_CHK, ST_FINISH
   } state_type;

   typedef struct packed {
      logic init;
      logic take;
      logic start;
      logic chk_walk;
      logic rd_q;
      logic chk_q;
      logic link_q;
      logic link_node;
      logic chk_red;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic reject;
      logic fld_zero;
      logic fld_is_q;
      logic cur_root;
      logic len_ok;
   } status_type;
endpackage

// ===== hdl/sab_req_if.sv =====
// ---------------------------------------------------------------------------
// sab_req_if
// Symbol channel: one word carries one symbol.
// ---------------------------------------------------------------------------
interface sab_req_if;
   logic                 valid;
   logic                 ready;
   sab_pkg::symbol_type  symbol;
   modport source (output valid, output symbol, input ready);
   modport sink (input valid, input symbol, output ready);
endinterface

// ===== hdl/sab_rsp_if.sv =====
// ---------------------------------------------------------------------------
// sab_rsp_if
// Result channel: one word per symbol with the count of new substrings.
// ---------------------------------------------------------------------------
interface sab_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [sab_pkg::NEW_W-1:0]         new_substrings;
   logic [sab_pkg::TOTAL_W-1:0]       total_distinct;
   logic                              full_res;
   modport source (output valid, output new_substrings, output total_distinct,
                   output full_res, input ready);
   modport sink (input valid, input new_substrings, input total_distinct,
                 input full_res, output ready);
endinterface

// ===== hdl/suffix_automaton_builder.sv =====
// Sequence after a symbol is accepted: a rejected symbol goes straight to the
// result word; else the suffix-link walk reads one node per step, a found edge
// has its target checked, and a target that must be cloned is copied before the
// redirect walk runs. Throughput: one symbol at a time, the next word is taken
// in the cycle after the result loads.
// Reset: synchronous; after reset the root node is written, then idle.
// ---------------------------------------------------------------------------
// suffix_automaton_builder
// Extends a suffix automaton by one symbol per word and reports substrings.
// ---------------------------------------------------------------------------
module suffix_automaton_builder (
   input logic      clock,
   input logic      reset,
   sab_req_if.sink  req_chan,
   sab_rsp_if.source rsp_chan
);
   sab_pkg::cmd_type    cmd;
   sab_pkg::status_type status;

   sab_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_ready(req_chan.ready),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
      .cmd(cmd), .status(status));

   sab_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_symbol(req_chan.symbol),
      .rsp_new_substrings(rsp_chan.new_substrings),
      .rsp_total_distinct(rsp_chan.total_distinct),
      .rsp_full_res(rsp_chan.full_res));
endmodule

// ===== hdl/sab_ram.sv =====
// ---------------------------------------------------------------------------
// sab_ram
// Generic memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module sab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/sab_datapath.sv =====
// ---------------------------------------------------------------------------
// sab_datapath
// Node tables, walk registers and the result word of the builder.
// ---------------------------------------------------------------------------
module sab_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  sab_pkg::cmd_type              cmd,
   output sab_pkg::status_type           status,
   input  sab_pkg::symbol_type           req_symbol,
   output logic [sab_pkg::NEW_W-1:0]     rsp_new_substrings,
   output logic [sab_pkg::TOTAL_W-1:0]   rsp_total_distinct,
   output logic                          rsp_full_res
);
   sab_pkg::symbol_type sym_ff;
   sab_pkg::node_type   node_ff, cur_ff, q_ff, cl_ff, last_ff, count_ff;
   sab_pkg::len_type    len_node_ff, len_cur_ff, link_len_ff, last_len_ff;
   sab_pkg::len_type            taken_ff;
   logic [sab_pkg::TOTAL_W-1:0] total_ff;
   logic [sab_pkg::NEW_W-1:0]   new_ff;
   logic                        full_ff;

   sab_pkg::row_type  tr_rd, tr_wdata, row_mod;
   sab_pkg::node_type tr_waddr, lk_waddr, ln_waddr, raddr, lk_rd, lk_wdata, fld, fld_val;
   sab_pkg::len_type  ln_rd, ln_wdata, added;
   logic tr_we, lk_we, ln_we, full, bad;

   assign full  = taken_ff >= sab_pkg::LEN_W'(sab_pkg::MAX_LEN);
   assign bad   = sym_ff >= sab_pkg::SYMBOL_W'(sab_pkg::ALPHABET);
   assign raddr = cmd.rd_q ? q_ff : cur_ff;
   assign fld   = tr_rd[32'(sym_ff) * sab_pkg::NODE_W +: sab_pkg::NODE_W];
   assign fld_val = cmd.chk_red ? cl_ff : node_ff;
   assign added = len_node_ff - link_len_ff;

   always_comb begin
      row_mod = tr_rd;
      row_mod[32'(sym_ff) * sab_pkg::NODE_W +: sab_pkg::NODE_W] = fld_val;
   end

   assign status.reject   = full | bad;
   assign status.fld_zero = fld == '0;
   assign status.fld_is_q = fld == q_ff;
   assign status.cur_root = cur_ff == '0;
   assign status.len_ok   = (len_cur_ff + 1'b1) == ln_rd;

   // Write port selection for the three tables.
   always_comb begin
      tr_we = 1'b0; tr_waddr = node_ff; tr_wdata = '0;
      ln_we = 1'b0; ln_waddr = '0;      ln_wdata = '0;
      lk_we = 1'b0; lk_waddr = node_ff; lk_wdata = '0;
      priority if (cmd.init) begin
         tr_we = 1'b1; tr_waddr = '0;
         ln_we = 1'b1;
      end else if (cmd.start) begin
         tr_we = 1'b1; tr_waddr = count_ff;
         ln_we = 1'b1; ln_waddr = count_ff; ln_wdata = last_len_ff + 1'b1;
      end else if (cmd.chk_walk) begin
         tr_we = status.fld_zero; tr_waddr = cur_ff; tr_wdata = row_mod;
         lk_we = status.fld_zero & status.cur_root;
      end else if (cmd.chk_q) begin
         if (status.len_ok) begin
            lk_we = 1'b1; lk_wdata = q_ff;
         end else begin
            tr_we = 1'b1; tr_waddr = count_ff; tr_wdata = tr_rd;
            ln_we = 1'b1; ln_waddr = count_ff; ln_wdata = len_cur_ff + 1'b1;
            lk_we = 1'b1; lk_waddr = count_ff; lk_wdata = lk_rd;
         end
      end else if (cmd.link_q) begin
         lk_we = 1'b1; lk_waddr = q_ff; lk_wdata = cl_ff;
      end else if (cmd.link_node) begin
         lk_we = 1'b1; lk_wdata = cl_ff;
      end else if (cmd.chk_red) begin
         tr_we = status.fld_is_q; tr_waddr = cur_ff; tr_wdata = row_mod;
      end else begin
         tr_we = 1'b0;
      end
   end

   sab_ram #(.WIDTH(sab_pkg::ROW_W), .DEPTH(sab_pkg::NODES)) u_trans (
      .clock(clock), .wr_en(tr_we), .wr_addr(tr_waddr), .wr_data(tr_wdata),
      .rd_addr(raddr), .rd_data(tr_rd));
   sab_ram #(.WIDTH(sab_pkg::LEN_W), .DEPTH(sab_pkg::NODES)) u_len (
      .clock(clock), .wr_en(ln_we), .wr_addr(ln_waddr), .wr_data(ln_wdata),
      .rd_addr(raddr), .rd_data(ln_rd));
   sab_ram #(.WIDTH(sab_pkg::NODE_W), .DEPTH(sab_pkg::NODES)) u_link (
      .clock(clock), .wr_en(lk_we), .wr_addr(lk_waddr), .wr_data(lk_wdata),
      .rd_addr(raddr), .rd_data(lk_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff     <= '0;
         last_len_ff <= '0;
         count_ff    <= sab_pkg::NODE_W'(1);
         taken_ff    <= '0;
         total_ff    <= '0;
      end else begin
         if (cmd.start) begin
            count_ff <= count_ff + 1'b1;
         end else if (cmd.chk_q && !status.len_ok) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.finish && !status.reject) begin
            last_ff     <= node_ff;
            last_len_ff <= len_node_ff;
            taken_ff    <= taken_ff + 1'b1;
            total_ff    <= total_ff + sab_pkg::TOTAL_W'(added);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         sym_ff <= req_symbol;
      end
      if (cmd.start) begin
         node_ff     <= count_ff;
         cur_ff      <= last_ff;
         len_node_ff <= last_len_ff + 1'b1;
      end
      if (cmd.chk_walk) begin
         if (status.fld_zero) begin
            if (status.cur_root) begin
               link_len_ff <= '0;
            end else begin
               cur_ff <= lk_rd;
            end
         end else begin
            q_ff       <= fld;
            len_cur_ff <= ln_rd;
         end
      end
      if (cmd.chk_q) begin
         link_len_ff <= ln_rd;
         cl_ff       <= count_ff;
      end
      if (cmd.link_node) begin
         link_len_ff <= len_cur_ff + 1'b1;
      end
      if (cmd.chk_red && status.fld_is_q && !status.cur_root) begin
         cur_ff <= lk_rd;
      end
      if (cmd.finish) begin
         new_ff  <= status.reject ? '0 : sab_pkg::NEW_W'(added);
         full_ff <= full;
      end
   end

   assign rsp_new_substrings = new_ff;
   assign rsp_total_distinct = total_ff;
   assign rsp_full_res       = full_ff;
endmodule

// ===== hdl/sab_controller.sv =====
// ---------------------------------------------------------------------------
// sab_controller
// Sequences the suffix-link walk, the clone and the redirect walk.
// ---------------------------------------------------------------------------
`include "suffix_automaton_builder_assert.svh"

module sab_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sab_pkg::cmd_type     cmd,
   input  sab_pkg::status_type  status
);
   sab_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in, slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sab_pkg::ST_INIT:      state_in = sab_pkg::ST_IDLE;
         sab_pkg::ST_IDLE:      if (req_valid) state_in = sab_pkg::ST_START;
         sab_pkg::ST_START:
            state_in = status.reject ? sab_pkg::ST_FINISH : sab_pkg::ST_WALK_RD;
         sab_pkg::ST_WALK_RD:   state_in = sab_pkg::ST_WALK_CHK;
         sab_pkg::ST_WALK_CHK: begin
            priority if (!status.fld_zero) state_in = sab_pkg::ST_Q_RD;
            else if (status.cur_root)      state_in = sab_pkg::ST_FINISH;
            else                           state_in = sab_pkg::ST_WALK_RD;
         end
         sab_pkg::ST_Q_RD:      state_in = sab_pkg::ST_Q_CHK;
         sab_pkg::ST_Q_CHK:
            state_in = status.len_ok ? sab_pkg::ST_FINISH : sab_pkg::ST_LINK_Q;
         sab_pkg::ST_LINK_Q:    state_in = sab_pkg::ST_LINK_NODE;
         sab_pkg::ST_LINK_NODE: state_in = sab_pkg::ST_RED_RD;
         sab_pkg::ST_RED_RD:    state_in = sab_pkg::ST_RED_CHK;
         sab_pkg::ST_RED_CHK: begin
            if (!status.fld_is_q || status.cur_root) state_in = sab_pkg::ST_FINISH;
            else                                     state_in = sab_pkg::ST_RED_RD;
         end
         sab_pkg::ST_FINISH:    if (slot_free) state_in = sab_pkg::ST_IDLE;
         default:               state_in = sab_pkg::ST_INIT;
      endcase
   end

   always_comb begin
      cmd           = '0;
      req_ready     = 1'b0;
      cmd.init      = state_ff == sab_pkg::ST_INIT;
      req_ready     = state_ff == sab_pkg::ST_IDLE;
      cmd.take      = req_ready && req_valid;
      cmd.start     = state_ff == sab_pkg::ST_START && !status.reject;
      cmd.chk_walk  = state_ff == sab_pkg::ST_WALK_CHK;
      cmd.rd_q      = state_ff == sab_pkg::ST_Q_RD;
      cmd.chk_q     = state_ff == sab_pkg::ST_Q_CHK;
      cmd.link_q    = state_ff == sab_pkg::ST_LINK_Q;
      cmd.link_node = state_ff == sab_pkg::ST_LINK_NODE;
      cmd.chk_red   = state_ff == sab_pkg::ST_RED_CHK;
      cmd.finish    = state_ff == sab_pkg::ST_FINISH && slot_free;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.finish) rsp_valid_in = 1'b1;
      else if (rsp_ready)      rsp_valid_in = 1'b0;
      else                     rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sab_pkg::ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `SAB_ASSERT_NEXT(a_accept_busy, req_valid && req_ready, state_ff == sab_pkg::ST_START)
   `SAB_ASSERT_NEXT(a_finish_shows, cmd.finish, rsp_valid && state_ff == sab_pkg::ST_IDLE)
   `SAB_ASSERT_NEXT(a_clone_links, state_ff == sab_pkg::ST_LINK_Q, cmd.link_node)
   `SAB_ASSERT_SAME(a_one_walk_write, cmd.chk_walk || cmd.chk_red, !cmd.finish && !req_ready)
endmodule
